// File: design/grsp_pkg.sv
package grsp_pkg;

    localparam int SINE_DEPTH = 256;
    localparam int SINE_AW    = $clog2(SINE_DEPTH);
    localparam int ANG_W      = SINE_AW + 2;
    localparam int ANG_Q      = ANG_W + 1;
    localparam int TAB_W      = 16;

    localparam int MODE_W    = 2;
    localparam int TICK_W    = 16;
    localparam int INDEX_W   = 2;
    localparam int CFG_W     = 27;
    localparam int RATE_W    = 16;
    localparam int CYCLE_W   = 27;
    localparam int RAMP_W    = 24;
    localparam int ELAPSED_W = 28;
    localparam int RATIO_W   = 17;
    localparam int FRAC_W    = 16;
    localparam int SPEED_W   = 17;
    localparam int PHASE_W   = 2;
    localparam int MAG_W     = RATIO_W;
    localparam int NUM_W     = CYCLE_W + ANG_W + 1;

    localparam int DIV_W  = TICK_W + FRAC_W;
    localparam int REM_W  = CYCLE_W;
    localparam int DCNT_W = $clog2(DIV_W + 1);

    localparam int MCAND_W  = RATIO_W + RATE_W;
    localparam int MPLIER_W = RATIO_W;
    localparam int PROD_W   = MCAND_W + MPLIER_W;
    localparam int MCNT_W   = $clog2(MPLIER_W + 1);
    localparam int RND_SH   = 32;

    localparam logic [RATIO_W-1:0] ONE_Q16 = RATIO_W'(65536);
    localparam logic [15:0]        MAG_MAX = 16'hFFFF;

    localparam logic [RATE_W-1:0]  RATE_RST  = RATE_W'(30720);
    localparam logic [CYCLE_W-1:0] CYCLE_RST = CYCLE_W'(60000000);
    localparam logic [RAMP_W-1:0]  RAMP_RST  = RAMP_W'(3000000);

    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_START = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STOP  = 2'd2;

    localparam logic [INDEX_W-1:0] REG_RATE  = 2'd0;
    localparam logic [INDEX_W-1:0] REG_CYCLE = 2'd1;
    localparam logic [INDEX_W-1:0] REG_RAMP  = 2'd2;

    localparam logic [PHASE_W-1:0] PH_IDLE  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_ACCEL = 2'd1;
    localparam logic [PHASE_W-1:0] PH_RUN   = 2'd2;
    localparam logic [PHASE_W-1:0] PH_DECEL = 2'd3;

    localparam logic [63:0] ONE_Q30 = 64'd1073741824;
    localparam logic [63:0] PI2_Q30 = 64'd1686629713;
    localparam logic [63:0] SERIES_DIV [6] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

    typedef struct packed {
        logic              load;
        logic [REM_W-1:0]  rem_init;
        logic [DIV_W-1:0]  dividend;
        logic [REM_W-1:0]  divisor;
        logic [DCNT_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic [DIV_W-1:0] quotient;
        logic [REM_W-1:0] remainder;
    } div_rsp_t;

    typedef struct packed {
        logic                load;
        logic [MCAND_W-1:0]  mcand;
        logic [MPLIER_W-1:0] mplier;
    } mul_req_t;

    typedef struct packed {
        logic              busy;
        logic [PROD_W-1:0] product;
    } mul_rsp_t;

    typedef struct packed {
        logic             sin_neg;
        logic [MAG_W-1:0] sin_mag;
        logic             cos_neg;
        logic [MAG_W-1:0] cos_mag;
    } trig_t;

    // Quarter-wave sine entry in Q0.16 from a short Taylor series in Q30.
    function automatic logic [TAB_W-1:0] sine_q16(input int unsigned idx);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        int          j;
        x = (PI2_Q30 * 64'(idx)) / SINE_DEPTH;
        x2 = (x * x) >> 30;
        t = ONE_Q30;
        for (j = 0; j < 6; j++)
        begin
            t = ONE_Q30 - ((x2 * t) >> 30) / SERIES_DIV[j];
        end
        s = (x * t) >> 30;
        s = (s + 64'd8192) >> 14;
        if (s > 64'd65535)
        begin
            s = 64'd65535;
        end
        return s[TAB_W-1:0];
    endfunction

endpackage

// File: design/grsp_if.sv
interface grsp_cmd_if
    import grsp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [TICK_W-1:0] tick_us;

    modport source(output valid, mode, tick_us, input ready);
    modport sink(input valid, mode, tick_us, output ready);
endinterface

interface grsp_speed_if
    import grsp_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      drive_on;
    logic signed [SPEED_W-1:0] pitch_speed;
    logic signed [SPEED_W-1:0] roll_speed;
    logic                      calibrating;
    logic [PHASE_W-1:0]        phase_now;

    modport source(output valid, drive_on, pitch_speed, roll_speed, calibrating, phase_now,
                   input ready);
    modport sink(input valid, drive_on, pitch_speed, roll_speed, calibrating, phase_now,
                 output ready);
endinterface

interface grsp_cfg_if
    import grsp_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] index;
    logic [CFG_W-1:0]   data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// File: design/grsp_div.sv
module grsp_div
    import grsp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg;
    logic              busy_next;
    logic [DCNT_W-1:0] cnt_reg;
    logic [DCNT_W-1:0] cnt_next;
    logic [REM_W-1:0]  rem_reg;
    logic [REM_W-1:0]  rem_next;
    logic [REM_W-1:0]  den_reg;
    logic [REM_W-1:0]  den_next;
    logic [DIV_W-1:0]  num_reg;
    logic [DIV_W-1:0]  num_next;
    logic [DIV_W-1:0]  quo_reg;
    logic [DIV_W-1:0]  quo_next;
    logic [REM_W:0]    shifted;
    logic [REM_W:0]    trial;
    logic              ge;

    assign shifted = {rem_reg, num_reg[DIV_W-1]};
    assign ge      = shifted >= {1'b0, den_reg};
    assign trial   = shifted - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        if (req.load)
        begin
            busy_next = 1'b1;
            cnt_next  = req.steps;
            rem_next  = req.rem_init;
            den_next  = req.divisor;
            num_next  = req.dividend;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? trial[REM_W-1:0] : shifted[REM_W-1:0];
            num_next  = {num_reg[DIV_W-2:0], 1'b0};
            quo_next  = {quo_reg[DIV_W-2:0], ge};
            cnt_next  = cnt_reg - DCNT_W'(1);
            busy_next = (cnt_reg != DCNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        num_reg <= num_next;
        quo_reg <= quo_next;
    end

    assign rsp.busy      = busy_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// File: design/grsp_mul.sv
module grsp_mul
    import grsp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    logic                busy_reg;
    logic                busy_next;
    logic [MCNT_W-1:0]   cnt_reg;
    logic [MCNT_W-1:0]   cnt_next;
    logic [MCAND_W-1:0]  a_reg;
    logic [MCAND_W-1:0]  a_next;
    logic [MCAND_W-1:0]  hi_reg;
    logic [MCAND_W-1:0]  hi_next;
    logic [MPLIER_W-1:0] lo_reg;
    logic [MPLIER_W-1:0] lo_next;
    logic [MCAND_W:0]    sum;

    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        if (req.load)
        begin
            busy_next = 1'b1;
            cnt_next  = MCNT_W'(MPLIER_W);
            a_next    = req.mcand;
            hi_next   = '0;
            lo_next   = req.mplier;
        end
        else if (busy_reg)
        begin
            hi_next   = sum[MCAND_W:1];
            lo_next   = {sum[0], lo_reg[MPLIER_W-1:1]};
            cnt_next  = cnt_reg - MCNT_W'(1);
            busy_next = (cnt_reg != MCNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg  <= a_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign rsp.busy    = busy_reg;
    assign rsp.product = {hi_reg, lo_reg};

endmodule

// File: design/grsp_sine.sv
module grsp_sine
    import grsp_pkg::*;
(
    input  logic             clk,
    input  logic             lookup,
    input  logic [ANG_W-1:0] angle,
    output trig_t            trig
);

    localparam logic [SINE_AW:0] DEPTH_K = (SINE_AW + 1)'(SINE_DEPTH);

    logic [TAB_W-1:0]   quarter_tab [SINE_DEPTH];
    logic [1:0]         quad_s;
    logic [1:0]         quad_c;
    logic [SINE_AW-1:0] r;
    logic [SINE_AW:0]   k_sin;
    logic [SINE_AW:0]   k_cos;
    trig_t              trig_reg;
    trig_t              trig_next;

    for (genvar g = 0; g < SINE_DEPTH; g++)
    begin : g_tab
        localparam logic [TAB_W-1:0] ENTRY = sine_q16(g);
        assign quarter_tab[g] = ENTRY;
    end

    assign quad_s = angle[ANG_W-1:SINE_AW];
    assign quad_c = quad_s + 2'd1;
    assign r      = angle[SINE_AW-1:0];
    assign k_sin  = quad_s[0] ? (DEPTH_K - {1'b0, r}) : {1'b0, r};
    assign k_cos  = quad_c[0] ? (DEPTH_K - {1'b0, r}) : {1'b0, r};

    always_comb
    begin
        trig_next.sin_neg = quad_s[1];
        trig_next.cos_neg = quad_c[1];
        trig_next.sin_mag = k_sin[SINE_AW] ? ONE_Q16 : {1'b0, quarter_tab[k_sin[SINE_AW-1:0]]};
        trig_next.cos_mag = k_cos[SINE_AW] ? ONE_Q16 : {1'b0, quarter_tab[k_cos[SINE_AW-1:0]]};
    end

    always_ff @(posedge clk)
    begin
        if (lookup)
        begin
            trig_reg <= trig_next;
        end
    end

    assign trig = trig_reg;

endmodule

// File: design/gimbal_ramp_sine_speed_profile.sv
// Channel   Direction  Word
// cfg       in         index, data: writes rotation rate, sweep length or ramp time
// cmd       in         mode, tick_us: tick, start event or stop event
// speed     out        drive_on, pitch_speed, roll_speed, calibrating, phase_now
//
// For a tick, a 32-step bit-serial divider forms the ramp step while a second divider
// forms the sweep angle, a 17-step multiplier scales the rate by the ratio, the sine
// table is read, and two 17-step multipliers form the speeds in parallel.
// Start and stop events and unused modes give no word and leave the sequencer idle.
// Reset loads the register defaults and puts the sequencer in the idle phase.
// A finished word waits in the output register while the next command is taken.
module gimbal_ramp_sine_speed_profile
    import grsp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    grsp_cfg_if.sink   cfg,
    grsp_cmd_if.sink   cmd,
    grsp_speed_if.source speed
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_ANG  = 3'd2;
    localparam logic [2:0] S_TAB  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;

    logic [2:0]                state_reg;
    logic [2:0]                state_next;
    logic [PHASE_W-1:0]        phase_reg;
    logic [PHASE_W-1:0]        phase_next;
    logic [RATIO_W-1:0]        ratio_reg;
    logic [RATIO_W-1:0]        ratio_next;
    logic [ELAPSED_W-1:0]      elapsed_reg;
    logic [ELAPSED_W-1:0]      elapsed_next;
    logic                      drive_reg;
    logic                      drive_next;
    logic [RATE_W-1:0]         rate_reg;
    logic [CYCLE_W-1:0]        cycle_reg;
    logic [RAMP_W-1:0]         ramp_reg;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic                      out_drive_reg;
    logic signed [SPEED_W-1:0] pitch_reg;
    logic signed [SPEED_W-1:0] roll_reg;
    logic                      calib_reg;
    logic [PHASE_W-1:0]        phase_out_reg;
    logic                      out_load;

    logic [ELAPSED_W:0]        elapsed_sum;
    logic [RATIO_W-1:0]        inc;
    logic [RATIO_W:0]          ratio_sum;
    logic [NUM_W-1:0]          ang_num;
    logic [ANG_W-1:0]          angle;
    logic                      lookup;

    div_req_t div0_req;
    div_req_t div1_req;
    div_rsp_t div0_rsp;
    div_rsp_t div1_rsp;
    mul_req_t mul0_req;
    mul_req_t mul1_req;
    mul_rsp_t mul0_rsp;
    mul_rsp_t mul1_rsp;
    trig_t    trig;

    function automatic logic [SPEED_W-1:0] speed_word(input logic [PROD_W-1:0] p,
                                                       input logic neg);
        logic [PROD_W-RND_SH:0] q;
        logic [15:0]            m;
        q = {1'b0, p[PROD_W-1:RND_SH]} + (PROD_W - RND_SH + 1)'(p[RND_SH-1]);
        m = (q > (PROD_W - RND_SH + 1)'(MAG_MAX)) ? MAG_MAX : q[15:0];
        return neg ? (SPEED_W'(0) - {1'b0, m}) : {1'b0, m};
    endfunction

    grsp_div u_div_ramp (.clk(clk), .rst_n(rst_n), .req(div0_req), .rsp(div0_rsp));
    grsp_div u_div_angle (.clk(clk), .rst_n(rst_n), .req(div1_req), .rsp(div1_rsp));
    grsp_mul u_mul_pitch (.clk(clk), .rst_n(rst_n), .req(mul0_req), .rsp(mul0_rsp));
    grsp_mul u_mul_roll (.clk(clk), .rst_n(rst_n), .req(mul1_req), .rsp(mul1_rsp));
    grsp_sine u_sine (.clk(clk), .lookup(lookup), .angle(angle), .trig(trig));

    assign cmd.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    assign elapsed_sum = {1'b0, elapsed_reg} + (ELAPSED_W + 1)'(cmd.tick_us);
    assign inc = (div0_rsp.quotient > DIV_W'(ONE_Q16)) ? ONE_Q16
                                                        : div0_rsp.quotient[RATIO_W-1:0];
    assign ratio_sum = {1'b0, ratio_reg} + {1'b0, inc};
    assign ang_num = {1'b0, div1_rsp.remainder, ANG_W'(0)} + NUM_W'(cycle_reg >> 1);
    assign angle = (cycle_reg == '0) ? '0 : div1_rsp.quotient[ANG_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        ratio_next     = ratio_reg;
        elapsed_next   = elapsed_reg;
        drive_next     = drive_reg;
        out_valid_next = out_valid_reg && !speed.ready;
        out_load       = 1'b0;
        lookup         = 1'b0;
        div0_req       = '0;
        div1_req       = '0;
        mul0_req       = '0;
        mul1_req       = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    case (cmd.mode)
                        MODE_TICK:
                        begin
                            case (phase_reg)
                                PH_ACCEL: elapsed_next = '0;
                                PH_RUN:
                                begin
                                    elapsed_next = elapsed_sum[ELAPSED_W] ? '1
                                                 : elapsed_sum[ELAPSED_W-1:0];
                                end
                                default: elapsed_next = elapsed_reg;
                            endcase
                            div0_req.load     = 1'b1;
                            div0_req.dividend = {cmd.tick_us, FRAC_W'(0)};
                            div0_req.divisor  = REM_W'(ramp_reg);
                            div0_req.steps    = DCNT_W'(DIV_W);
                            div1_req.load     = 1'b1;
                            div1_req.dividend = {elapsed_next, (DIV_W - ELAPSED_W)'(0)};
                            div1_req.divisor  = cycle_reg;
                            div1_req.steps    = DCNT_W'(ELAPSED_W);
                            state_next        = S_DIV;
                        end
                        MODE_START: phase_next = PH_ACCEL;
                        MODE_STOP:  phase_next = PH_DECEL;
                        default:    phase_next = phase_reg;
                    endcase
                end
            end
            S_DIV:
            begin
                if (!div0_rsp.busy && !div1_rsp.busy)
                begin
                    drive_next = (phase_reg != PH_IDLE);
                    case (phase_reg)
                        PH_IDLE: ratio_next = '0;
                        PH_ACCEL:
                        begin
                            if (ratio_sum >= {1'b0, ONE_Q16})
                            begin
                                ratio_next = ONE_Q16;
                                phase_next = PH_RUN;
                            end
                            else
                            begin
                                ratio_next = ratio_sum[RATIO_W-1:0];
                            end
                        end
                        PH_RUN: ratio_next = ratio_reg;
                        default:
                        begin
                            if (ratio_reg <= inc)
                            begin
                                ratio_next = '0;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                ratio_next = ratio_reg - inc;
                            end
                        end
                    endcase
                    if ((phase_next == PH_RUN) && (elapsed_reg > ELAPSED_W'(cycle_reg)))
                    begin
                        phase_next = PH_DECEL;
                    end
                    div1_req.load     = 1'b1;
                    div1_req.rem_init = REM_W'(ang_num[NUM_W-1:ANG_Q]);
                    div1_req.dividend = {ang_num[ANG_Q-1:0], (DIV_W - ANG_Q)'(0)};
                    div1_req.divisor  = cycle_reg;
                    div1_req.steps    = DCNT_W'(ANG_Q);
                    mul0_req.load     = 1'b1;
                    mul0_req.mcand    = MCAND_W'(rate_reg);
                    mul0_req.mplier   = ratio_next;
                    state_next        = S_ANG;
                end
            end
            S_ANG:
            begin
                if (!div1_rsp.busy && !mul0_rsp.busy)
                begin
                    lookup     = 1'b1;
                    state_next = S_TAB;
                end
            end
            S_TAB:
            begin
                mul0_req.load   = 1'b1;
                mul0_req.mcand  = mul0_rsp.product[MCAND_W-1:0];
                mul0_req.mplier = trig.sin_mag;
                mul1_req.load   = 1'b1;
                mul1_req.mcand  = mul0_rsp.product[MCAND_W-1:0];
                mul1_req.mplier = trig.cos_mag;
                state_next      = S_MUL;
            end
            S_MUL:
            begin
                if (!mul0_rsp.busy && !mul1_rsp.busy && (!out_valid_reg || speed.ready))
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_IDLE;
            ratio_reg     <= '0;
            elapsed_reg   <= '0;
            drive_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            rate_reg      <= RATE_RST;
            cycle_reg     <= CYCLE_RST;
            ramp_reg      <= RAMP_RST;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            ratio_reg     <= ratio_next;
            elapsed_reg   <= elapsed_next;
            drive_reg     <= drive_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_RATE:  rate_reg  <= cfg.data[RATE_W-1:0];
                    REG_CYCLE: cycle_reg <= cfg.data[CYCLE_W-1:0];
                    REG_RAMP:  ramp_reg  <= cfg.data[RAMP_W-1:0];
                    default:   rate_reg  <= rate_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_drive_reg <= drive_reg;
            pitch_reg     <= speed_word(mul0_rsp.product, trig.sin_neg);
            roll_reg      <= speed_word(mul1_rsp.product, trig.cos_neg);
            calib_reg     <= (phase_reg == PH_RUN);
            phase_out_reg <= phase_reg;
        end
    end

    assign speed.valid       = out_valid_reg;
    assign speed.drive_on    = out_drive_reg;
    assign speed.pitch_speed = pitch_reg;
    assign speed.roll_speed  = roll_reg;
    assign speed.calibrating = calib_reg;
    assign speed.phase_now   = phase_out_reg;

endmodule
